[rtl/ps2_scan_code_to_ascii_receiver_top_macros.svh]
// Assertion macros for the PS/2 scan code receiver checker.
// Used by the checker file only; expects aclk and aresetn in scope.
`ifndef PS2_SCAN_CODE_TO_ASCII_RECEIVER_TOP_MACROS_SVH
`define PS2_SCAN_CODE_TO_ASCII_RECEIVER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PS2SC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PS2SC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/ps2sc_pkg.sv]
// Package for the PS/2 scan code receiver: word types, scan codes,
// frame constants and the two character tables. No dependencies.
`default_nettype none

package ps2sc_pkg;

    // Width of the idle tick counter
    localparam int IDLE_COUNT_WIDTH = 16;
    localparam int TIMEOUT_WIDTH    = 16;
    // Common width used to compare counter and timeout
    localparam int IDLE_CMP_WIDTH   = (IDLE_COUNT_WIDTH > TIMEOUT_WIDTH) ?
                                      IDLE_COUNT_WIDTH : TIMEOUT_WIDTH;

    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd50;

    // Scan codes with a special meaning
    localparam logic [7:0] CODE_BREAK  = 8'hF0;
    localparam logic [7:0] CODE_LSHIFT = 8'h12;

    // Frame positions: 0 start, 1..8 data, 9 parity, 10 stop
    localparam logic [3:0] POS_START     = 4'd0;
    localparam logic [3:0] POS_DATA_LAST = 4'd8;
    localparam logic [3:0] POS_FRAME_END = 4'd10;

    // Operation codes of an input word
    localparam logic OP_BIT  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [IDLE_COUNT_WIDTH-1:0] idle_count_t;
    typedef logic [TIMEOUT_WIDTH-1:0]    timeout_t;

    typedef struct packed {
        logic operation;
        logic data_bit;
    } in_word_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic       message_end;
    } out_word_t;

    // Outcome of decoding one scan code
    typedef struct packed {
        logic       emit;
        logic [7:0] char_code;
        logic       shift_held;
        logic       break_pending;
    } decode_t;

    // Characters with shift held; unmapped codes give zero
    function automatic logic [7:0] shifted_char(input logic [7:0] code);
        logic [7:0] ch;
        case (code)
            8'h15: ch = "Q";
            8'h16: ch = "!";
            8'h1A: ch = "Z";
            8'h1B: ch = "S";
            8'h1C: ch = "A";
            8'h1D: ch = "W";
            8'h21: ch = "C";
            8'h22: ch = "X";
            8'h23: ch = "D";
            8'h24: ch = "E";
            8'h25: ch = "$";
            8'h26: ch = "#";
            8'h2A: ch = "V";
            8'h2B: ch = "F";
            8'h2C: ch = "T";
            8'h2D: ch = "R";
            8'h2E: ch = "%";
            8'h31: ch = "N";
            8'h32: ch = "B";
            8'h33: ch = "H";
            8'h34: ch = "G";
            8'h35: ch = "Y";
            8'h36: ch = "^";
            8'h3A: ch = "M";
            8'h3B: ch = "J";
            8'h3C: ch = "U";
            8'h3D: ch = "&";
            8'h3E: ch = "*";
            8'h41: ch = "<";
            8'h42: ch = "K";
            8'h43: ch = "I";
            8'h44: ch = "O";
            8'h45: ch = ")";
            8'h46: ch = "(";
            8'h49: ch = ">";
            8'h4A: ch = "?";
            8'h4B: ch = "L";
            8'h4C: ch = ":";
            8'h4D: ch = "P";
            8'h52: ch = 8'h22;  // double quote
            8'h55: ch = "+";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters without shift; unmapped codes give zero
    function automatic logic [7:0] plain_char(input logic [7:0] code);
        logic [7:0] ch;
        case (code)
            8'h16: ch = "1";
            8'h1E: ch = "2";
            8'h25: ch = "4";
            8'h26: ch = "3";
            8'h29: ch = " ";
            8'h2E: ch = "5";
            8'h36: ch = "6";
            8'h3D: ch = "7";
            8'h3E: ch = "8";
            8'h41: ch = ",";
            8'h45: ch = "0";
            8'h46: ch = "9";
            8'h49: ch = ".";
            8'h4A: ch = "/";
            8'h4C: ch = ";";
            8'h4E: ch = "-";
            8'h52: ch = 8'h27;  // single quote
            8'h55: ch = "=";
            8'h5A: ch = 8'h0A;  // line feed
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/ps2sc_decode.sv]
// Scan code decoder: break and shift tracking plus table lookup.
// Depends on ps2sc_pkg.
`default_nettype none

module ps2sc_decode (
    input  wire logic [7:0]        code,
    input  wire logic              shift_held,
    input  wire logic              break_pending,
    output ps2sc_pkg::decode_t     result
);

    // Pick the table by shift state
    logic [7:0] table_char;
    assign table_char = shift_held ? ps2sc_pkg::shifted_char(code)
                                   : ps2sc_pkg::plain_char(code);

    // Break prefix arms, shift code sets or (after a break) clears shift, anything else is a key
    always_comb begin
        result.emit          = 1'b0;
        result.char_code     = 8'h00;
        result.shift_held    = shift_held;
        result.break_pending = 1'b0;
        if (code == ps2sc_pkg::CODE_BREAK) begin
            result.break_pending = 1'b1;
        end else if (code == ps2sc_pkg::CODE_LSHIFT) begin
            result.shift_held = !break_pending;
        end else if (!break_pending) begin
            result.emit      = 1'b1;
            result.char_code = table_char;
        end
    end

endmodule

`default_nettype wire

[rtl/ps2sc_in_stage.sv]
// Input register stage: holds one accepted word until the engine takes it.
// Depends on ps2sc_pkg.
`default_nettype none

module ps2sc_in_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output wire logic                 s_ready,
    input  wire ps2sc_pkg::in_word_t  s_data,
    output wire logic                 word_valid,
    output ps2sc_pkg::in_word_t       word,
    input  wire logic                 word_pop
);

    logic                valid_reg;
    logic                valid_next;
    ps2sc_pkg::in_word_t word_reg;

    // Take a new word whenever the slot is empty or drains this cycle
    assign s_ready    = !valid_reg || word_pop;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (word_pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload; load on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

[rtl/ps2sc_engine.sv]
// Frame engine: frame position, shift register, idle timer and result
// register. Depends on ps2sc_pkg and ps2sc_decode.
`default_nettype none

module ps2sc_engine (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ps2sc_pkg::timeout_t   idle_timeout_ms,
    input  wire logic                  word_valid,
    input  wire ps2sc_pkg::in_word_t   word,
    output wire logic                  word_pop,
    output wire logic                  m_valid,
    input  wire logic                  m_ready,
    output ps2sc_pkg::out_word_t       m_data
);

    logic [3:0]                pos_reg, pos_next;
    logic [7:0]                sr_reg, sr_next;
    logic                      shift_reg, shift_next;
    logic                      break_reg, break_next;
    logic                      recv_reg, recv_next;
    ps2sc_pkg::idle_count_t    idle_reg, idle_next;
    logic                      out_valid_reg, out_valid_next;
    ps2sc_pkg::out_word_t      out_word_reg, out_word_next;

    logic                      advance;
    logic [7:0]                sr_shifted;
    logic [7:0]                dec_code;
    logic                      in_data;
    logic                      timed_out;
    ps2sc_pkg::idle_count_t    idle_inc;
    ps2sc_pkg::decode_t        dec;
    logic                      has_result;

    // Move a word forward only when the result slot can take it
    assign advance  = word_valid && (!out_valid_reg || m_ready);
    assign word_pop = advance;

    assign in_data    = (pos_reg != ps2sc_pkg::POS_START) &&
                        (pos_reg <= ps2sc_pkg::POS_DATA_LAST);
    assign sr_shifted = {word.data_bit, sr_reg[7:1]};
    assign dec_code   = (word.operation == ps2sc_pkg::OP_BIT) ? sr_shifted : sr_reg;

    // Saturating idle count and timeout compare
    assign idle_inc  = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;
    assign timed_out = ps2sc_pkg::IDLE_CMP_WIDTH'(idle_inc) >=
                       ps2sc_pkg::IDLE_CMP_WIDTH'(idle_timeout_ms);

    ps2sc_decode u_decode (
        .code          (dec_code),
        .shift_held    (shift_reg),
        .break_pending (break_reg),
        .result        (dec)
    );

    // Next state and result for the word in the input stage
    always_comb begin
        pos_next      = pos_reg;
        sr_next       = sr_reg;
        shift_next    = shift_reg;
        break_next    = break_reg;
        recv_next     = recv_reg;
        idle_next     = idle_reg;
        has_result    = 1'b0;
        out_word_next = out_word_reg;
        if (advance) begin
            if (word.operation == ps2sc_pkg::OP_BIT) begin
                recv_next = 1'b1;
                idle_next = '0;
                if (pos_reg == ps2sc_pkg::POS_START) begin
                    sr_next = 8'h00;
                end else if (in_data) begin
                    sr_next = sr_shifted;
                end
                if (pos_reg == ps2sc_pkg::POS_DATA_LAST) begin
                    shift_next = dec.shift_held;
                    break_next = dec.break_pending;
                    if (dec.emit) begin
                        has_result                = 1'b1;
                        out_word_next.char_valid  = 1'b1;
                        out_word_next.char_code   = dec.char_code;
                        out_word_next.message_end = 1'b0;
                    end
                end
                pos_next = (pos_reg >= ps2sc_pkg::POS_FRAME_END) ? ps2sc_pkg::POS_START
                                                                 : pos_reg + 4'd1;
            end else if (recv_reg) begin
                if (!timed_out) begin
                    idle_next = idle_inc;
                end else begin
                    // End the message: flush a partial frame, then clear
                    has_result                = 1'b1;
                    out_word_next.char_valid  = in_data && dec.emit;
                    out_word_next.char_code   = (in_data && dec.emit) ? dec.char_code
                                                                      : 8'h00;
                    out_word_next.message_end = 1'b1;
                    pos_next   = ps2sc_pkg::POS_START;
                    sr_next    = 8'h00;
                    shift_next = 1'b0;
                    break_next = 1'b0;
                    recv_next  = 1'b0;
                    idle_next  = '0;
                end
            end
        end
    end

    // Result slot: fill on a new result, drop once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= ps2sc_pkg::POS_START;
            sr_reg        <= 8'h00;
            shift_reg     <= 1'b0;
            break_reg     <= 1'b0;
            recv_reg      <= 1'b0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            sr_reg        <= sr_next;
            shift_reg     <= shift_next;
            break_reg     <= break_next;
            recv_reg      <= recv_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

`default_nettype wire

[rtl/ps2_scan_code_to_ascii_receiver_top.sv]
// PS/2 set-2 scan code receiver with ASCII translation, top level.
// Depends on ps2sc_pkg, ps2sc_in_stage, ps2sc_engine and ps2sc_decode.
//
// Input words (s_valid/s_ready/s_data) are either a sampled keyboard data
// bit (operation 0) or a one millisecond tick (operation 1). Eleven bits form
// a frame; after the eighth data bit the scan code is decoded and a plain or
// shifted character word goes out on m_valid/m_ready/m_data. Once ticks since
// the last bit reach idle_timeout_ms, an end-of-message word goes out and the
// frame state clears; a partial frame is decoded into that same word.
// cfg_wr_en/cfg_wr_data write idle_timeout_ms (reset value 50);
// write it only while the block is idle.
// Each accepted word waits in the input register; the engine decodes it and
// writes any result into the output register. Throughput: one word per cycle
// while the output is not stalled, set by the combinational decode between those two registers.
// A stalled output holds its word; the input stage keeps one more word, then
// s_ready drops until m_ready returns. Synchronous active-low reset empties
// both stages and clears all frame state.
`default_nettype none

module ps2_scan_code_to_ascii_receiver_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire ps2sc_pkg::timeout_t   cfg_wr_data,
    input  wire logic                  s_valid,
    output wire logic                  s_ready,
    input  wire ps2sc_pkg::in_word_t   s_data,
    output wire logic                  m_valid,
    input  wire logic                  m_ready,
    output ps2sc_pkg::out_word_t       m_data
);

    ps2sc_pkg::timeout_t  timeout_reg;
    logic                 word_valid;
    logic                 word_pop;
    ps2sc_pkg::in_word_t  word;

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ps2sc_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    ps2sc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .word_valid (word_valid),
        .word       (word),
        .word_pop   (word_pop)
    );

    ps2sc_engine u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .idle_timeout_ms (timeout_reg),
        .word_valid      (word_valid),
        .word            (word),
        .word_pop        (word_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

`default_nettype wire

[rtl/ps2sc_checker.sv]
// Port-level checker for the PS/2 scan code receiver, bound to the top.
// Depends on ps2sc_pkg and the assertion macro header.
`default_nettype none

`include "ps2_scan_code_to_ascii_receiver_top_macros.svh"

module ps2sc_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire ps2sc_pkg::out_word_t  m_data
);

    logic out_stall;
    logic no_char;

    assign out_stall = m_valid && !m_ready;
    assign no_char   = m_valid && !m_data.char_valid;

    // A stalled result word holds
    `PS2SC_ASSERT(a_out_hold, out_stall |=> m_valid && $stable(m_data), "stalled word moved")

    // Reset empties the result slot
    `PS2SC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // Every result word carries a character or a message end
    `PS2SC_ASSERT(a_content, m_valid |-> m_data.char_valid || m_data.message_end, "empty word")

    // No character means a zero code
    `PS2SC_ASSERT(a_zero_code, no_char |-> m_data.char_code == 8'h00, "stray code")

    // An empty result slot never holds off the input
    `PS2SC_ASSERT(a_ready_empty, !m_valid |-> s_ready, "input stalled while empty")

endmodule

bind ps2_scan_code_to_ascii_receiver_top ps2sc_checker u_ps2sc_checker (.*);

`default_nettype wire
